[design/eks_pkg.sv]
// Shared widths, register indexes and mode flag positions for the key scan sequencer.
// No dependencies.
package eks_pkg;

	localparam int KEY_W     = 48;
	localparam int STEP_W    = 5;
	localparam int CHIP_W    = 7;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int FLAG_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SELECT_CHIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_CHIP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_CHIP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LED_CHIP    = 2'd3;

	localparam logic [CHIP_W-1:0] SELECT_CHIP_RST = 7'h38;
	localparam logic [CHIP_W-1:0] COLUMN_CHIP_RST = 7'h39;
	localparam logic [CHIP_W-1:0] BUTTON_CHIP_RST = 7'h3A;
	localparam logic [CHIP_W-1:0] LED_CHIP_RST    = 7'h3B;

	localparam int FLAG_BURST    = 0;
	localparam int FLAG_RELEASE  = 1;
	localparam int FLAG_SUSTAIN  = 2;
	localparam int FLAG_ARPEGGIO = 3;
	localparam int BTN_WAVE      = 4;

	localparam logic [BYTE_W-1:0] BUTTONS_RELEASED = 8'hFF;

	typedef logic [FLAG_W-1:0] flags_t;

endpackage

[design/expander_key_scan_sequencer_unit.sv]
// Key scan sequencer: steps a round of expander transactions and keeps key map and mode flags.
// Depends on eks_pkg.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------------------
//  in      | in  | in_valid/in_ready   | read_byte
//  out     | out | out_valid/out_ready | next_chip, next_is_read, next_write_byte, key_map, flags
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat in, one out next cycle; a new beat is taken every cycle unless the result stalls.
// The result register is the only stage; input is taken while the held result is taken.
// A stalled result holds the input side; cfg_ready is always high.
// After reset the row 0 select write sits on the result fields; out_valid stays low until a beat.
module expander_key_scan_sequencer_unit
	import eks_pkg::*;
#(
	parameter int ROWS         = 8,
	parameter int BITS_PER_ROW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    read_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHIP_W-1:0]    next_chip,
	output logic                 next_is_read,
	output logic [BYTE_W-1:0]    next_write_byte,
	output logic [KEY_W-1:0]     key_map,
	output logic                 burst_on,
	output logic                 release_on,
	output logic                 sustain_on,
	output logic                 arpeggio_on,
	output logic                 wave_is_rectangle,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CHIP_W-1:0]    cfg_data
);

	localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(1);
	localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(2 * ROWS + 2);
	localparam logic [STEP_W-1:0] BTN_STEP   = STEP_W'(2 * ROWS + 1);
	localparam logic [STEP_W-1:0] ROW_END    = STEP_W'(2 * ROWS);

	logic [CHIP_W-1:0] select_chip_q, column_chip_q, button_chip_q, led_chip_q;
	logic [STEP_W-1:0] step_q, step_cur, step_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [BYTE_W-1:0] prev_btn_q, prev_btn_d;
	flags_t            flags_q, flags_d, falls;
	logic              wave_q, wave_d;
	logic              out_valid_q;
	logic [CHIP_W-1:0] chip_q, chip_d;
	logic              is_read_q, is_read_d;
	logic [BYTE_W-1:0] wbyte_q, wbyte_d;
	logic              take;

	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_chip_q <= SELECT_CHIP_RST;
			column_chip_q <= COLUMN_CHIP_RST;
			button_chip_q <= BUTTON_CHIP_RST;
			led_chip_q    <= LED_CHIP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SELECT_CHIP: select_chip_q <= cfg_data;
				REG_COLUMN_CHIP: column_chip_q <= cfg_data;
				REG_BUTTON_CHIP: button_chip_q <= cfg_data;
				REG_LED_CHIP:    led_chip_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		step_cur = (step_q == '0 || step_q > LAST_STEP) ? FIRST_STEP : step_q;
		key_d      = key_q;
		flags_d    = flags_q;
		wave_d     = wave_q;
		prev_btn_d = prev_btn_q;
		falls      = (~read_byte[FLAG_W-1:0]) & prev_btn_q[FLAG_W-1:0];

		for (int r = 0; r < ROWS; r++) begin
			if (step_cur == STEP_W'(2 * r + 2)) begin
				for (int j = 0; j < BITS_PER_ROW; j++) begin
					if (BITS_PER_ROW * r + j < KEY_W)
						key_d[BITS_PER_ROW * r + j] = ~read_byte[j];
				end
			end
		end

		if (step_cur == BTN_STEP) begin
			flags_d = flags_q ^ falls;
			wave_d  = ~read_byte[BTN_WAVE];
			if (flags_d[FLAG_ARPEGGIO] && !flags_q[FLAG_ARPEGGIO]) begin
				flags_d[FLAG_SUSTAIN] = 1'b0;
				flags_d[FLAG_RELEASE] = 1'b0;
			end
			if (flags_d[FLAG_ARPEGGIO] && (flags_d[FLAG_SUSTAIN] || flags_d[FLAG_RELEASE]))
				flags_d[FLAG_ARPEGGIO] = 1'b0;
			prev_btn_d = read_byte;
		end

		step_d = (step_cur >= LAST_STEP) ? FIRST_STEP : step_cur + FIRST_STEP;

		if (step_d <= ROW_END) begin
			if (step_d[0]) begin
				chip_d    = select_chip_q;
				is_read_d = 1'b0;
				wbyte_d   = ~(BYTE_W'(1) << step_d[3:1]);
			end else begin
				chip_d    = column_chip_q;
				is_read_d = 1'b1;
				wbyte_d   = '0;
			end
		end else if (step_d == BTN_STEP) begin
			chip_d    = button_chip_q;
			is_read_d = 1'b1;
			wbyte_d   = '0;
		end else begin
			chip_d    = led_chip_q;
			is_read_d = 1'b0;
			wbyte_d   = {{(BYTE_W - FLAG_W){1'b1}}, ~flags_d};
		end
	end

	// reset state is the row 0 select write pending, held until the first beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= FIRST_STEP;
			key_q       <= '0;
			prev_btn_q  <= BUTTONS_RELEASED;
			flags_q     <= '0;
			wave_q      <= 1'b0;
			out_valid_q <= 1'b0;
			chip_q      <= SELECT_CHIP_RST;
			is_read_q   <= 1'b0;
			wbyte_q     <= ~BYTE_W'(1);
		end else begin
			out_valid_q <= take || (out_valid_q && !out_ready);
			if (take) begin
				step_q      <= step_d;
				key_q       <= key_d;
				prev_btn_q  <= prev_btn_d;
				flags_q     <= flags_d;
				wave_q      <= wave_d;
				chip_q      <= chip_d;
				is_read_q   <= is_read_d;
				wbyte_q     <= wbyte_d;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign next_chip         = chip_q;
	assign next_is_read      = is_read_q;
	assign next_write_byte   = wbyte_q;
	assign key_map           = key_q;
	assign burst_on          = flags_q[FLAG_BURST];
	assign release_on        = flags_q[FLAG_RELEASE];
	assign sustain_on        = flags_q[FLAG_SUSTAIN];
	assign arpeggio_on       = flags_q[FLAG_ARPEGGIO];
	assign wave_is_rectangle = wave_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q >= FIRST_STEP && step_q <= LAST_STEP)
		else $error("scan step out of round");

	a_arp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags_q[FLAG_ARPEGGIO] && (flags_q[FLAG_SUSTAIN] || flags_q[FLAG_RELEASE])))
		else $error("arpeggio set with sustain or release");

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("accepted beat produced no result");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && is_read_q |-> wbyte_q == '0)
		else $error("read transaction carries write data");

endmodule
